/* design/vcs_pkg.sv */
package vcs_pkg;

  // Fixed field widths
  localparam int VALUE_BITS     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int PROD_BITS      = 2 * VALUE_BITS;
  localparam int GRID_COLS_BITS = 11;
  localparam int GRID_ROWS_BITS = 16;
  localparam int INV_BITS       = 31;
  localparam int NODE_COL_BITS  = 10;
  localparam int NODE_ROW_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 31;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int MIN_GRID       = 3;
  localparam int GRID_ROWS_RST  = 1024;
  localparam int GRID_COLS_RST  = 1024;
  localparam int INV_RST        = 65536;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRID_COLS = 2'd0,
    REG_GRID_ROWS = 2'd1,
    REG_INV_H1_SQ = 2'd2,
    REG_INV_H2_SQ = 2'd3
  } cfg_reg_e;

  // Controller states, one per datapath step
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_MID,
    ST_ROW_NEXT,
    ST_MUL_XR,
    ST_MUL_XL,
    ST_MUL_YU,
    ST_MUL_YD,
    ST_MUL_FX,
    ST_DIFF_FY,
    ST_MUL_FY,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_ROW_MID,
    OP_ROW_NEXT,
    OP_MUL_XR,
    OP_MUL_XL,
    OP_MUL_YU,
    OP_MUL_YD,
    OP_MUL_FX,
    OP_DIFF_FY,
    OP_MUL_FY,
    OP_ROUND,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic [NODE_COL_BITS-1:0] col;
    logic [NODE_ROW_BITS-1:0] row;
    logic                     last;
  } node_tag_t;

  typedef struct packed {
    dp_op_e    op;
    node_tag_t tag;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // One line-store entry: previous-previous row value, previous row value and coefficients
  typedef struct packed {
    value_t above;
    value_t mid;
    value_t cx;
    value_t cy;
  } line_entry_t;

endpackage

/* design/vcs_cfg.sv */
module vcs_cfg #(
  parameter int MAX_COLS = vcs_pkg::MAX_COLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [vcs_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  output logic [$clog2(MAX_COLS+1)-1:0]        cols_eff_o,
  output logic [vcs_pkg::GRID_ROWS_BITS-1:0]   rows_eff_o,
  output logic [vcs_pkg::INV_BITS-1:0]         inv_h1_sq_o,
  output logic [vcs_pkg::INV_BITS-1:0]         inv_h2_sq_o,
  output logic                                 restart_o
);

  localparam int CNT_W    = $clog2(MAX_COLS + 1);
  localparam int CMP_W    = ((CNT_W > vcs_pkg::GRID_COLS_BITS) ? CNT_W
                                                               : vcs_pkg::GRID_COLS_BITS) + 1;
  localparam int COLS_RST = (MAX_COLS < vcs_pkg::GRID_COLS_RST) ? MAX_COLS
                                                                : vcs_pkg::GRID_COLS_RST;

  logic [CNT_W-1:0]                   cols_eff_q, cols_eff_d;
  logic [vcs_pkg::GRID_ROWS_BITS-1:0] rows_eff_q, rows_eff_d;
  logic [vcs_pkg::INV_BITS-1:0]       inv_h1_q, inv_h2_q;
  logic [CMP_W-1:0]                   cols_wr;
  logic [vcs_pkg::GRID_ROWS_BITS-1:0] rows_wr;

  // Store sizes already clamped to the supported range
  always_comb begin
    cols_wr = CMP_W'(cfg_data_i[vcs_pkg::GRID_COLS_BITS-1:0]);
    rows_wr = cfg_data_i[vcs_pkg::GRID_ROWS_BITS-1:0];
    if (cols_wr < CMP_W'(vcs_pkg::MIN_GRID)) begin
      cols_eff_d = CNT_W'(vcs_pkg::MIN_GRID);
    end else if (cols_wr > CMP_W'(MAX_COLS)) begin
      cols_eff_d = CNT_W'(MAX_COLS);
    end else begin
      cols_eff_d = CNT_W'(cols_wr);
    end
    if (rows_wr < vcs_pkg::GRID_ROWS_BITS'(vcs_pkg::MIN_GRID)) begin
      rows_eff_d = vcs_pkg::GRID_ROWS_BITS'(vcs_pkg::MIN_GRID);
    end else begin
      rows_eff_d = rows_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_eff_q <= CNT_W'(COLS_RST);
      rows_eff_q <= vcs_pkg::GRID_ROWS_BITS'(vcs_pkg::GRID_ROWS_RST);
      inv_h1_q   <= vcs_pkg::INV_BITS'(vcs_pkg::INV_RST);
      inv_h2_q   <= vcs_pkg::INV_BITS'(vcs_pkg::INV_RST);
    end else if (cfg_we_i) begin
      case (vcs_pkg::cfg_reg_e'(cfg_index_i))
        vcs_pkg::REG_GRID_COLS: cols_eff_q <= cols_eff_d;
        vcs_pkg::REG_GRID_ROWS: rows_eff_q <= rows_eff_d;
        vcs_pkg::REG_INV_H1_SQ: inv_h1_q   <= cfg_data_i[vcs_pkg::INV_BITS-1:0];
        vcs_pkg::REG_INV_H2_SQ: inv_h2_q   <= cfg_data_i[vcs_pkg::INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign restart_o   = cfg_we_i &&
                       (cfg_index_i == vcs_pkg::REG_GRID_COLS ||
                        cfg_index_i == vcs_pkg::REG_GRID_ROWS);
  assign cols_eff_o  = cols_eff_q;
  assign rows_eff_o  = rows_eff_q;
  assign inv_h1_sq_o = inv_h1_q;
  assign inv_h2_sq_o = inv_h2_q;

endmodule

/* design/vcs_ctrl.sv */
module vcs_ctrl #(
  parameter int MAX_COLS = vcs_pkg::MAX_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]       cols_eff_i,
  input  logic [vcs_pkg::GRID_ROWS_BITS-1:0]  rows_eff_i,
  input  vcs_pkg::dp_status_t                 status_i,
  output vcs_pkg::dp_cmd_t                    cmd_o,
  output logic [$clog2(MAX_COLS)-1:0]         rd_addr_o,
  output logic [$clog2(MAX_COLS)-1:0]         wr_addr_o
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int CMP_W = CNT_W + 1;
  localparam int ROW_W = vcs_pkg::GRID_ROWS_BITS;

  vcs_pkg::state_e  state_q, state_d;
  logic             accept;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] cur_col_q;
  logic [ROW_W-1:0] cur_row_q;
  logic             has_res_q, has_res_d;
  logic             last_q, last_d;

  logic [CMP_W-1:0] col_p1, col_p2, cols_x;
  logic [ROW_W:0]   row_p1;

  assign accept = in_valid_i && (state_q == vcs_pkg::ST_IDLE);

  // Position of the arriving item and what it triggers
  always_comb begin
    cols_x    = CMP_W'(cols_eff_i);
    col_p1    = CMP_W'(col_q) + CMP_W'(1);
    col_p2    = CMP_W'(col_q) + CMP_W'(2);
    row_p1    = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(1);
    has_res_d = (row_q >= ROW_W'(2)) && (col_q != '0) && (col_p2 <= cols_x);
    last_d    = (col_p2 == cols_x) && (row_p1 == (ROW_W + 1)'(rows_eff_i));
    if (col_p1 >= cols_x) begin
      col_d = '0;
      row_d = (row_p1 >= (ROW_W + 1)'(rows_eff_i)) ? '0 : row_p1[ROW_W-1:0];
    end else begin
      col_d = col_p1[COL_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      has_res_q <= 1'b0;
      last_q    <= 1'b0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q     <= col_d;
      row_q     <= row_d;
      has_res_q <= has_res_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_col_q <= col_q;
      cur_row_q <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vcs_pkg::ST_IDLE:     if (accept) state_d = vcs_pkg::ST_ROW_MID;
      vcs_pkg::ST_ROW_MID:  state_d = vcs_pkg::ST_ROW_NEXT;
      vcs_pkg::ST_ROW_NEXT: state_d = has_res_q ? vcs_pkg::ST_MUL_XR : vcs_pkg::ST_IDLE;
      vcs_pkg::ST_MUL_XR:   state_d = vcs_pkg::ST_MUL_XL;
      vcs_pkg::ST_MUL_XL:   state_d = vcs_pkg::ST_MUL_YU;
      vcs_pkg::ST_MUL_YU:   state_d = vcs_pkg::ST_MUL_YD;
      vcs_pkg::ST_MUL_YD:   state_d = vcs_pkg::ST_MUL_FX;
      vcs_pkg::ST_MUL_FX:   state_d = vcs_pkg::ST_DIFF_FY;
      vcs_pkg::ST_DIFF_FY:  state_d = vcs_pkg::ST_MUL_FY;
      vcs_pkg::ST_MUL_FY:   state_d = vcs_pkg::ST_ROUND;
      vcs_pkg::ST_ROUND:    state_d = vcs_pkg::ST_EMIT;
      vcs_pkg::ST_EMIT:     if (status_i.out_free) state_d = vcs_pkg::ST_IDLE;
      default:              state_d = vcs_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op       = vcs_pkg::OP_NONE;
    cmd_o.tag.col  = vcs_pkg::NODE_COL_BITS'(cur_col_q);
    cmd_o.tag.row  = cur_row_q - ROW_W'(1);
    cmd_o.tag.last = last_q;
    in_stall_o     = 1'b1;
    rd_addr_o      = col_q;
    wr_addr_o      = cur_col_q;
    case (state_q)
      vcs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) cmd_o.op = vcs_pkg::OP_LOAD_IN;
      end
      vcs_pkg::ST_ROW_MID: begin
        cmd_o.op  = vcs_pkg::OP_ROW_MID;
        rd_addr_o = cur_col_q + COL_W'(1);
      end
      vcs_pkg::ST_ROW_NEXT: cmd_o.op = vcs_pkg::OP_ROW_NEXT;
      vcs_pkg::ST_MUL_XR:   cmd_o.op = vcs_pkg::OP_MUL_XR;
      vcs_pkg::ST_MUL_XL:   cmd_o.op = vcs_pkg::OP_MUL_XL;
      vcs_pkg::ST_MUL_YU:   cmd_o.op = vcs_pkg::OP_MUL_YU;
      vcs_pkg::ST_MUL_YD:   cmd_o.op = vcs_pkg::OP_MUL_YD;
      vcs_pkg::ST_MUL_FX:   cmd_o.op = vcs_pkg::OP_MUL_FX;
      vcs_pkg::ST_DIFF_FY:  cmd_o.op = vcs_pkg::OP_DIFF_FY;
      vcs_pkg::ST_MUL_FY:   cmd_o.op = vcs_pkg::OP_MUL_FY;
      vcs_pkg::ST_ROUND:    cmd_o.op = vcs_pkg::OP_ROUND;
      vcs_pkg::ST_EMIT: begin
        if (status_i.out_free) cmd_o.op = vcs_pkg::OP_EMIT;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(col_q) < cols_eff_i)
    else $error("column counter beyond grid width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < rows_eff_i)
    else $error("row counter beyond grid height");

  a_last_is_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> has_res_q)
    else $error("last-node flag on a boundary node");
`endif

endmodule

/* design/vcs_dp.sv */
module vcs_dp #(
  parameter int MAX_COLS = vcs_pkg::MAX_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vcs_pkg::dp_cmd_t                    cmd_i,
  output vcs_pkg::dp_status_t                 status_o,
  input  logic [$clog2(MAX_COLS)-1:0]         rd_addr_i,
  input  logic [$clog2(MAX_COLS)-1:0]         wr_addr_i,
  input  vcs_pkg::value_t                     coef_x_i,
  input  vcs_pkg::value_t                     coef_y_i,
  input  vcs_pkg::value_t                     grid_value_i,
  input  logic [vcs_pkg::INV_BITS-1:0]        inv_h1_sq_i,
  input  logic [vcs_pkg::INV_BITS-1:0]        inv_h2_sq_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output vcs_pkg::value_t                     op_value_o,
  output logic [vcs_pkg::NODE_COL_BITS-1:0]   node_col_o,
  output logic [vcs_pkg::NODE_ROW_BITS-1:0]   node_row_o,
  output logic                                last_node_o
);

  localparam int VB = vcs_pkg::VALUE_BITS;
  localparam int PB = vcs_pkg::PROD_BITS;

  localparam vcs_pkg::value_t VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam vcs_pkg::value_t VMIN = {1'b1, {(VB-1){1'b0}}};

  // x - y, saturated
  function automatic vcs_pkg::value_t sat_sub(vcs_pkg::value_t x, vcs_pkg::value_t y);
    logic [VB:0] d;
    d = {x[VB-1], x} - {y[VB-1], y};
    if (d[VB] != d[VB-1]) begin
      return d[VB] ? VMIN : VMAX;
    end
    return vcs_pkg::value_t'(d[VB-1:0]);
  endfunction

  // Q16.16 rescale, round half away from zero, saturate
  function automatic vcs_pkg::value_t round_sat(vcs_pkg::prod_t p);
    vcs_pkg::prod_t s;
    vcs_pkg::prod_t sh;
    s  = p + (p[PB-1] ? PB'((1 << (vcs_pkg::FRAC_BITS - 1)) - 1)
                      : PB'(1 << (vcs_pkg::FRAC_BITS - 1)));
    sh = s >>> vcs_pkg::FRAC_BITS;
    if (!(&sh[PB-1:VB-1]) && (|sh[PB-1:VB-1])) begin
      return sh[PB-1] ? VMIN : VMAX;
    end
    return vcs_pkg::value_t'(sh[VB-1:0]);
  endfunction

  vcs_pkg::line_entry_t line_mem_q [MAX_COLS];
  vcs_pkg::line_entry_t rd_entry_q;
  vcs_pkg::line_entry_t wr_entry;

  vcs_pkg::value_t a_q, b_q, w_q;
  vcs_pkg::value_t wc_q, above_q, cxc_q, cyc_q, cxr_q, left_q;
  vcs_pkg::value_t dxr_q, dxl_q, dyu_q, dyd_q;
  vcs_pkg::value_t rq_q, t_q, f_q;
  vcs_pkg::prod_t  prod_q, prod_d;
  vcs_pkg::value_t mul_a, mul_b;
  logic            mul_en;

  logic                 out_valid_q;
  logic                 out_free;
  vcs_pkg::value_t      op_value_q;
  vcs_pkg::node_tag_t   tag_q;

  // Line store: one write, one registered read per cycle
  assign wr_entry = '{above: rd_entry_q.mid, mid: w_q, cx: a_q, cy: b_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vcs_pkg::OP_ROW_MID) line_mem_q[wr_addr_i] <= wr_entry;
    rd_entry_q <= line_mem_q[rd_addr_i];
  end

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      vcs_pkg::OP_MUL_XR: begin mul_a = cxr_q; mul_b = dxr_q; end
      vcs_pkg::OP_MUL_XL: begin mul_a = cxc_q; mul_b = dxl_q; end
      vcs_pkg::OP_MUL_YU: begin mul_a = b_q;   mul_b = dyu_q; end
      vcs_pkg::OP_MUL_YD: begin mul_a = cyc_q; mul_b = dyd_q; end
      vcs_pkg::OP_MUL_FX: begin
        mul_a = f_q;
        mul_b = vcs_pkg::value_t'({1'b0, inv_h1_sq_i});
      end
      vcs_pkg::OP_MUL_FY: begin
        mul_a = f_q;
        mul_b = vcs_pkg::value_t'({1'b0, inv_h2_sq_i});
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= prod_d;
    rq_q <= round_sat(prod_q);
    case (cmd_i.op)
      vcs_pkg::OP_LOAD_IN: begin
        a_q <= coef_x_i;
        b_q <= coef_y_i;
        w_q <= grid_value_i;
      end
      vcs_pkg::OP_ROW_MID: begin
        wc_q    <= rd_entry_q.mid;
        above_q <= rd_entry_q.above;
        cxc_q   <= rd_entry_q.cx;
        cyc_q   <= rd_entry_q.cy;
      end
      vcs_pkg::OP_ROW_NEXT: begin
        cxr_q  <= rd_entry_q.cx;
        dxr_q  <= sat_sub(rd_entry_q.mid, wc_q);
        dxl_q  <= sat_sub(wc_q, left_q);
        dyu_q  <= sat_sub(w_q, wc_q);
        dyd_q  <= sat_sub(wc_q, above_q);
        left_q <= wc_q;
      end
      vcs_pkg::OP_MUL_YU:  t_q <= rq_q;
      vcs_pkg::OP_MUL_YD:  f_q <= sat_sub(t_q, rq_q);
      vcs_pkg::OP_MUL_FX:  t_q <= rq_q;
      vcs_pkg::OP_DIFF_FY: f_q <= sat_sub(t_q, rq_q);
      vcs_pkg::OP_MUL_FY:  t_q <= sat_sub('0, rq_q);
      vcs_pkg::OP_EMIT: begin
        op_value_q <= sat_sub(t_q, rq_q);
        tag_q      <= cmd_i.tag;
      end
      default: ;
    endcase
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == vcs_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign op_value_o        = op_value_q;
  assign node_col_o        = tag_q.col;
  assign node_row_o        = tag_q.row;
  assign last_node_o       = tag_q.last;

`ifndef NO_ASSERTIONS
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == vcs_pkg::OP_EMIT |-> out_free)
    else $error("result written over one not yet taken");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == vcs_pkg::OP_EMIT))
    else $error("result shown without an emit step");
`endif

endmodule

/* design/variable_coefficient_stencil.sv */
// Intake: an item is taken only in the idle state, once the previous item is
//   through; an interior node also runs the multiply steps, a boundary node
//   does not. The pace is set by the single shared 32x32 multiplier and the
//   two line-store reads per item. Output back-pressure adds its stall cycles.
// Reset: counters at node (0,0), configuration registers at their defaults,
//   output empty; the line store is not cleared and needs no clearing pass.
module variable_coefficient_stencil #(
  parameter int MAX_COLS = vcs_pkg::MAX_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items: one grid node in raster order
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [31:0]                  coef_x_i,
  input  logic signed [31:0]                  coef_y_i,
  input  logic signed [31:0]                  grid_value_i,
  // result items: operator value for an interior node
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [31:0]                  op_value_o,
  output logic [9:0]                          node_col_o,
  output logic [15:0]                         node_row_o,
  output logic                                last_node_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [vcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [vcs_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);

  // Effective grid size and reciprocal squares
  logic [CNT_W-1:0]                   cols_eff;
  logic [vcs_pkg::GRID_ROWS_BITS-1:0] rows_eff;
  logic [vcs_pkg::INV_BITS-1:0]       inv_h1_sq;
  logic [vcs_pkg::INV_BITS-1:0]       inv_h2_sq;
  logic                               restart;

  // Controller <-> datapath
  vcs_pkg::dp_cmd_t    cmd;
  vcs_pkg::dp_status_t status;
  logic [COL_W-1:0]    rd_addr;
  logic [COL_W-1:0]    wr_addr;

  // Register file; a write of either grid size also restarts the raster at (0,0)
  vcs_cfg #(
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cols_eff_o  (cols_eff),
    .rows_eff_o  (rows_eff),
    .inv_h1_sq_o (inv_h1_sq),
    .inv_h2_sq_o (inv_h2_sq),
    .restart_o   (restart)
  );

  // Sequencer: raster counters, interior test, one datapath step per state.
  // Takes an item only in its idle state; a waiting result does not block
  // intake, only the final emit step.
  vcs_ctrl #(
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart),
    .cols_eff_i (cols_eff),
    .rows_eff_i (rows_eff),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  // Datapath: line store (previous two rows of w, previous row of a and b),
  // difference unit, shared multiplier with round/saturate, output register.
  // Node (i,j) is finished when node (i,j+1) arrives: the arriving b and w
  // supply the upper neighbor terms.
  vcs_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .coef_x_i     (coef_x_i),
    .coef_y_i     (coef_y_i),
    .grid_value_i (grid_value_i),
    .inv_h1_sq_i  (inv_h1_sq),
    .inv_h2_sq_i  (inv_h2_sq),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .op_value_o   (op_value_o),
    .node_col_o   (node_col_o),
    .node_row_o   (node_row_o),
    .last_node_o  (last_node_o)
  );

endmodule

/* sim/variable_coefficient_stencil_tb.sv */
module variable_coefficient_stencil_tb;

  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam int     SETTLE_CYCLES = 24;    // settle time after the queued results are out
  localparam int     HOLD_CYCLES   = 300;   // long output hold-off, enough to fill the block
  localparam int     RANDOM_NODES  = 380;
  localparam int     MAX_PRINTS    = 100;
  localparam vcs_pkg::value_t Q_ONE = 32'sh0001_0000;
  localparam vcs_pkg::value_t Q_MAX = 32'sh7fff_ffff;
  localparam vcs_pkg::value_t Q_MIN = 32'sh8000_0000;
  localparam longint SAT_HI        = 64'sd2147483647;
  localparam longint SAT_LO        = -64'sd2147483648;

  // one expected operator result
  typedef struct {
    vcs_pkg::value_t op_value;
    logic [9:0]      col;
    logic [15:0]     row;
    logic            last;
  } stencil_op_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall_o;
  vcs_pkg::value_t   coef_x     = '0;
  vcs_pkg::value_t   coef_y     = '0;
  vcs_pkg::value_t   grid_value = '0;
  logic              out_valid_o;
  logic              out_stall  = 1'b0;
  vcs_pkg::value_t   op_value_o;
  logic [9:0]        node_col_o;
  logic [15:0]       node_row_o;
  logic              last_node_o;
  logic              cfg_we     = 1'b0;
  vcs_pkg::cfg_reg_e cfg_index  = vcs_pkg::REG_GRID_COLS;
  logic [30:0]       cfg_data   = '0;

  // mirror of the block: configuration, line stores and raster position
  int unsigned     cols_reg, rows_reg;
  longint          inv_x, inv_y;
  vcs_pkg::value_t line_above [vcs_pkg::MAX_COLS_DEF];
  vcs_pkg::value_t line_mid   [vcs_pkg::MAX_COLS_DEF];
  vcs_pkg::value_t line_cx    [vcs_pkg::MAX_COLS_DEF];
  vcs_pkg::value_t line_cy    [vcs_pkg::MAX_COLS_DEF];
  vcs_pkg::value_t left_mid;
  int unsigned     col_pos, row_pos;

  stencil_op_t pending_ops[$];

  bit idle_on   = 1'b1;   // random gaps and stalls on both sides
  int hold_left = 0;      // cycles the receiver still holds off
  int recv_wait = 0;

  int cycle_count     = 0;
  int error_count     = 0;
  int nodes_sent      = 0;
  int results_checked = 0;
  int regs_written    = 0;

  always #6 clk_i = ~clk_i;

  variable_coefficient_stencil dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .coef_x_i    (coef_x),
    .coef_y_i    (coef_y),
    .grid_value_i(grid_value),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .op_value_o  (op_value_o),
    .node_col_o  (node_col_o),
    .node_row_o  (node_row_o),
    .last_node_o (last_node_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Fixed-point helpers, Q16.16 saturated to 32 bits
  // ---------------------------------------------------------------------------
  function automatic longint sat_q(input longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  function automatic longint diff_q(input longint x, input longint y);
    return sat_q(x - y);
  endfunction

  // exact product of magnitudes, round half away from zero, then saturate
  function automatic longint mul_q(input longint x, input longint y);
    longint mx, my, p;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    p  = (mx * my + 64'sd32768) >>> 16;
    return sat_q(((x < 0) != (y < 0)) ? -p : p);
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg < 3) return 3;
    if (cols_reg > vcs_pkg::MAX_COLS_DEF) return vcs_pkg::MAX_COLS_DEF;
    return cols_reg;
  endfunction

  function automatic int unsigned eff_rows();
    return (rows_reg < 3) ? 3 : rows_reg;
  endfunction

  task automatic reset_model();
    cols_reg = vcs_pkg::GRID_COLS_RST;
    rows_reg = vcs_pkg::GRID_ROWS_RST;
    inv_x    = vcs_pkg::INV_RST;
    inv_y    = vcs_pkg::INV_RST;
    for (int k = 0; k < vcs_pkg::MAX_COLS_DEF; k++) begin
      line_above[k] = '0;
      line_mid[k]   = '0;
      line_cx[k]    = '0;
      line_cy[k]    = '0;
    end
    left_mid = '0;
    col_pos  = 0;
    row_pos  = 0;
  endtask

  // Advance the mirror by one node; queue the operator value of the node above
  // when that node is interior.
  task automatic predict_operator(input vcs_pkg::value_t a, input vcs_pkg::value_t b,
                                  input vcs_pkg::value_t w);
    int unsigned cols, rows, c, r;
    longint      wc, fx, fy, res;
    stencil_op_t op;
    cols = eff_cols();
    rows = eff_rows();
    c    = (col_pos >= cols) ? cols - 1 : col_pos;
    r    = row_pos;
    wc   = line_mid[c];
    if (r >= 2 && c >= 1 && c + 2 <= cols) begin
      fx = diff_q(mul_q(line_cx[c+1], diff_q(line_mid[c+1], wc)),
                  mul_q(line_cx[c], diff_q(wc, left_mid)));
      fy = diff_q(mul_q(b, diff_q(w, wc)),
                  mul_q(line_cy[c], diff_q(wc, line_above[c])));
      res = diff_q(diff_q(0, mul_q(fx, inv_x)), mul_q(fy, inv_y));
      op.op_value = vcs_pkg::value_t'(res);
      op.col      = 10'(c);
      op.row      = 16'(r - 1);
      op.last     = (c + 2 == cols) && (r + 1 == rows);
      pending_ops.push_back(op);
    end
    line_above[c] = vcs_pkg::value_t'(wc);
    line_mid[c]   = w;
    line_cx[c]    = a;
    line_cy[c]    = b;
    left_mid      = vcs_pkg::value_t'(wc);
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic int pick_wait();
    return idle_on ? $urandom_range(0, 15) : 0;
  endfunction

  // mostly small values around the unit, some full-scale and corner values
  function automatic vcs_pkg::value_t rand_q();
    case ($urandom_range(0, 9))
      0, 1: return vcs_pkg::value_t'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return -32'sd1;
          default: return Q_ONE;
        endcase
      end
      default: return vcs_pkg::value_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_inv();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 31'h7fff_ffff;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(1, 32'h0004_0000));
    endcase
  endfunction

  task automatic write_reg(input vcs_pkg::cfg_reg_e idx, input logic [30:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    case (idx)
      vcs_pkg::REG_GRID_COLS: begin
        cols_reg = data[10:0];
        col_pos  = 0;
        row_pos  = 0;
      end
      vcs_pkg::REG_GRID_ROWS: begin
        rows_reg = data[15:0];
        col_pos  = 0;
        row_pos  = 0;
      end
      vcs_pkg::REG_INV_H1_SQ: inv_x = data;
      vcs_pkg::REG_INV_H2_SQ: inv_y = data;
      default: ;
    endcase
    regs_written++;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one node after a random gap and hold it until accepted.
  task automatic send_node(input vcs_pkg::value_t a, input vcs_pkg::value_t b,
                           input vcs_pkg::value_t w);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    coef_x     <= a;
    coef_y     <= b;
    grid_value <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_operator(a, b, w);
    nodes_sent++;
  endtask

  task automatic stream_nodes(input int count);
    repeat (count) send_node(rand_q(), rand_q(), rand_q());
  endtask

  // Sender pauses until every queued result is out, then lets the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_op();
    stencil_op_t want;
    if (pending_ops.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d at col %0d row %0d",
                                op_value_o, node_col_o, node_row_o));
    end else begin
      want = pending_ops.pop_front();
      if (op_value_o !== want.op_value)
        report_mismatch($sformatf("op_value at (%0d,%0d): got %0d, want %0d",
                                  want.col, want.row, op_value_o, want.op_value));
      if (node_col_o !== want.col)
        report_mismatch($sformatf("node_col: got %0d, want %0d", node_col_o, want.col));
      if (node_row_o !== want.row)
        report_mismatch($sformatf("node_row: got %0d, want %0d", node_row_o, want.row));
      if (last_node_o !== want.last)
        report_mismatch($sformatf("last_node at (%0d,%0d): got %b, want %b",
                                  want.col, want.row, last_node_o, want.last));
      results_checked++;
    end
  endtask

  // Receiver: check each accepted result, then stall for a fresh random count.
  // A requested hold-off overrides the per-item draw.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall == 1'b0) begin
      check_op();
      recv_wait = pick_wait();
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_ops.size());
      $display("** variable_coefficient_stencil: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Two 3x3 grids from clamped sizes. The first runs at the default
  // reciprocals with products that land exactly on half an LSB; the second
  // follows the end-of-grid wrap with full-scale values and maximum
  // reciprocals so every stage saturates.
  task automatic test_directed_grids();
    vcs_pkg::value_t tie_cx[9], tie_cy[9], tie_w[9];
    tie_cx = '{Q_ONE, Q_ONE, Q_ONE, Q_ONE, -32'sd1, 32'sd1, Q_ONE, Q_ONE, Q_ONE};
    tie_cy = '{Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'sd3, Q_ONE};
    tie_w  = '{32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sh8000, 32'sh10000,
               32'sd0, Q_ONE, 32'sd0};
    write_reg(vcs_pkg::REG_GRID_COLS, 31'd0);
    write_reg(vcs_pkg::REG_GRID_ROWS, 31'd0);
    idle_on = 1'b1;
    for (int k = 0; k < 9; k++) send_node(tie_cx[k], tie_cy[k], tie_w[k]);
    drain_results();
    write_reg(vcs_pkg::REG_INV_H1_SQ, 31'h7fff_ffff);
    write_reg(vcs_pkg::REG_INV_H2_SQ, 31'h7fff_ffff);
    for (int k = 0; k < 9; k++)
      send_node(k[0] ? Q_MIN : Q_MAX, (k % 3 == 0) ? Q_MAX : Q_MIN, k[0] ? Q_MAX : Q_MIN);
    drain_results();
  endtask

  // Output held off while nodes keep coming, so the block must stall its
  // input; halfway the sender stops until all results are out.
  task automatic test_backpressure();
    write_reg(vcs_pkg::REG_GRID_COLS, 31'd8);
    write_reg(vcs_pkg::REG_GRID_ROWS, 31'd6);
    write_reg(vcs_pkg::REG_INV_H1_SQ, 31'h0002_0000);
    write_reg(vcs_pkg::REG_INV_H2_SQ, 31'h0000_8000);
    idle_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    stream_nodes(24);
    drain_results();
    stream_nodes(24);
    drain_results();
  endtask

  // Mostly complete grids of random size and content; some run two grids back
  // to back, some are cut short and restarted by the next size write, and a
  // few use clamped sizes or a near-endless row count.
  task automatic test_random_grids();
    int unsigned cols_w, rows_w, span;
    int          random_nodes;
    random_nodes = 0;
    while (random_nodes < RANDOM_NODES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       cols_w = $urandom_range(0, 2);
        1:       cols_w = $urandom_range(11, 24);
        default: cols_w = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       rows_w = $urandom_range(0, 2);
        1:       rows_w = 65535;
        default: rows_w = $urandom_range(3, 7);
      endcase
      write_reg(vcs_pkg::REG_GRID_COLS, 31'(cols_w));
      write_reg(vcs_pkg::REG_GRID_ROWS, 31'(rows_w));
      if ($urandom_range(0, 1)) write_reg(vcs_pkg::REG_INV_H1_SQ, rand_inv());
      if ($urandom_range(0, 1)) write_reg(vcs_pkg::REG_INV_H2_SQ, rand_inv());
      span = eff_cols() * eff_rows();
      if (rows_w == 65535)
        span = eff_cols() * $urandom_range(3, 6);
      else if ($urandom_range(0, 5) == 0)
        span = $urandom_range(1, span - 1);
      else if ($urandom_range(0, 3) == 0)
        span = 2 * span;
      stream_nodes(span);
      random_nodes += span;
      drain_results();
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_grids();
    test_backpressure();
    test_random_grids();
    $display("Run covered %0d nodes, %0d operator results checked, %0d register writes",
             nodes_sent, results_checked, regs_written);
    $display("Included rounding ties, saturation, clamped sizes, grid wrap and restarts");
    if (error_count == 0 && pending_ops.size() == 0) begin
      $display("** variable_coefficient_stencil: PASSED **");
    end else begin
      $display("** variable_coefficient_stencil: FAILED **");
    end
    $finish;
  end

endmodule
